// ----- rtl/jsu_pkg.sv -----
// Shared types and codes for the JSON string unescaper.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NO_QUOTE     = 2'd0;
    localparam logic [1:0] ERR_UNTERMINATED = 2'd1;
    localparam logic [1:0] ERR_BAD_HEX      = 2'd2;
    localparam logic [1:0] ERR_BAD_ESCAPE   = 2'd3;

    // input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam int unsigned MAX_RES = 6;

    typedef struct packed {
        logic       op;
        logic [7:0] in_byte;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [1:0] error_code;
        logic       last;
    } t_out;

    // one result without its last flag
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [1:0] error_code;
    } t_slot;

    // all results caused by one input item
    typedef struct packed {
        logic [2:0]          count;
        t_slot [MAX_RES-1:0] slot;
    } t_cmd;

endpackage

`default_nettype wire

// ----- rtl/json_string_unescape_to_utf8.sv -----
// JSON string unescaper, top level: parser front end, command queue,
// result back end. Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back.
//
// Usage:
//   Input channel: push/full, payload i_item {op, in_byte}. op = 0 carries
//   one byte of JSON text, op = 1 marks the end of the input buffer.
//   Result channel: empty/pop, payload o_result {kind, out_byte,
//   error_code, last}. last marks the final result caused by one input.
//   Each input item gives 0 to 6 results.
//   Throughput: one input item per cycle while full is low and each item
//   yields at most one result; an item yielding N results occupies the
//   result port for N transfers, as the back end emits one result per pop.
//   Each item's results appear once its queue entry reaches the head.
//   The front end parses combinationally and stores the item's results as
//   one entry in a P_DEPTH-entry queue; full rises when the queue is full,
//   so a stalled receiver backs up into the input after P_DEPTH commands.
//   Items that give no result use no queue entry.
//   Reset (synchronous, active low): parser idle awaiting an opening quote,
//   queue empty.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_to_utf8 #(
    parameter int P_DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire jsu_pkg::t_in i_item,
    output logic              empty,
    input  wire logic         pop,
    output jsu_pkg::t_out     o_result
);

    jsu_pkg::t_cmd f_cmd;
    logic          f_cmd_valid;
    jsu_pkg::t_cmd q_head;
    logic          q_valid;
    logic          q_full;
    logic          b_rd;

    assign full = q_full;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_full      (q_full),
        .o_cmd       (f_cmd),
        .o_cmd_valid (f_cmd_valid)
    );

    jsu_queue #(
        .DEPTH (P_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_cmd_valid),
        .i_cmd   (f_cmd),
        .i_rd    (b_rd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    jsu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_head   (q_head),
        .i_pop    (pop),
        .o_rd     (b_rd),
        .o_empty  (empty),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // queued commands always carry at least one result
    a_nonzero_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> (q_head.count != 3'd0))
        else $error("empty command in queue");

    // close and error results end an item's burst
    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind != jsu_pkg::KIND_BYTE) |-> o_result.last)
        else $error("close or error result not marked last");

    // mid-burst transfer leaves more results waiting
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_result.last) |=> !empty)
        else $error("result burst cut short");

    // front never pushes into a full queue
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_cmd_valid |-> !q_full)
        else $error("command pushed while queue full");
`endif

endmodule

`default_nettype wire

// ----- rtl/jsu_front.sv -----
// Parser front end: accepts input items, tracks escape state and builds one
// result command per item. Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire jsu_pkg::t_in i_item,
    input  wire logic         i_full,
    output jsu_pkg::t_cmd     o_cmd,
    output logic              o_cmd_valid
);

    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_STR      = 3'd1;
    localparam logic [2:0] MODE_ESC      = 3'd2;
    localparam logic [2:0] MODE_HEX      = 3'd3;
    localparam logic [2:0] MODE_PAIR_BS  = 3'd4;
    localparam logic [2:0] MODE_PAIR_U   = 3'd5;
    localparam logic [2:0] MODE_PAIR_HEX = 3'd6;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef struct packed {
        logic          has;
        jsu_pkg::t_slot res;
        logic [2:0]    mode;
        logic          hex_clr;
    } t_step;

    typedef struct packed {
        logic [1:0]      n;
        logic [2:0][7:0] b;
    } t_u8;

    function automatic jsu_pkg::t_slot f_byte(input logic [7:0] b);
        jsu_pkg::t_slot s;
        s.kind       = jsu_pkg::KIND_BYTE;
        s.out_byte   = b;
        s.error_code = jsu_pkg::ERR_NO_QUOTE;
        return s;
    endfunction

    function automatic jsu_pkg::t_slot f_err(input logic [1:0] e);
        jsu_pkg::t_slot s;
        s.kind       = jsu_pkg::KIND_ERROR;
        s.out_byte   = 8'h00;
        s.error_code = e;
        return s;
    endfunction

    // plain string content
    function automatic t_step f_str(input logic [7:0] c);
        t_step s;
        s = '0;
        if (c == CH_QUOTE) begin
            s.has      = 1'b1;
            s.res.kind = jsu_pkg::KIND_CLOSE;
            s.mode     = MODE_IDLE;
        end else if (c == CH_BSLASH) begin
            s.mode = MODE_ESC;
        end else begin
            s.has  = 1'b1;
            s.res  = f_byte(c);
            s.mode = MODE_STR;
        end
        return s;
    endfunction

    // character after a backslash
    function automatic t_step f_esc(input logic [7:0] c);
        t_step s;
        s      = '0;
        s.has  = 1'b1;
        s.mode = MODE_STR;
        case (c)
            CH_QUOTE:  s.res = f_byte(CH_QUOTE);
            CH_SLASH:  s.res = f_byte(CH_SLASH);
            CH_BSLASH: s.res = f_byte(CH_BSLASH);
            CH_B:      s.res = f_byte(8'h08);
            CH_F:      s.res = f_byte(8'h0C);
            CH_N:      s.res = f_byte(8'h0A);
            CH_R:      s.res = f_byte(8'h0D);
            CH_T:      s.res = f_byte(8'h09);
            CH_U: begin
                s.has     = 1'b0;
                s.mode    = MODE_HEX;
                s.hex_clr = 1'b1;
            end
            default: begin
                s.res  = f_err(jsu_pkg::ERR_BAD_ESCAPE);
                s.mode = MODE_IDLE;
            end
        endcase
        return s;
    endfunction

    function automatic t_u8 f_utf8(input logic [15:0] p);
        t_u8 u;
        u = '0;
        if (p <= 16'h007F) begin
            u.n    = 2'd1;
            u.b[0] = {1'b0, p[6:0]};
        end else if (p <= 16'h07FF) begin
            u.n    = 2'd2;
            u.b[0] = {3'b110, p[10:6]};
            u.b[1] = {2'b10, p[5:0]};
        end else begin
            u.n    = 2'd3;
            u.b[0] = {4'b1110, p[15:12]};
            u.b[1] = {2'b10, p[11:6]};
            u.b[2] = {2'b10, p[5:0]};
        end
        return u;
    endfunction

    function automatic logic [4:0] f_hex(input logic [7:0] c);
        // bit 4: digit is valid
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_held, n_held;

    logic           accept;
    logic           h_emit;
    jsu_pkg::t_slot m [4];
    logic [2:0]     m_n;
    t_step          st, es;
    t_u8            u_val, u_held;
    logic [4:0]     hx;
    logic [15:0]    acc_sh;
    logic [20:0]    cp;
    logic [7:0]     c;

    assign c      = i_item.in_byte;
    assign accept = i_push && !i_full;
    assign st     = f_str(c);
    assign es     = f_esc(c);
    assign hx     = f_hex(c);
    assign acc_sh = {r_acc[11:0], hx[3:0]};
    assign u_val  = f_utf8(acc_sh);
    assign u_held = f_utf8({6'b110110, r_held});
    assign cp     = {1'b0, r_held, acc_sh[9:0]} + 21'h10000;

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_held = r_held;
        h_emit = 1'b0;
        m_n    = 3'd0;
        for (int i = 0; i < 4; i++) begin
            m[i] = '0;
        end

        if (i_item.op == jsu_pkg::OP_END) begin
            case (r_mode)
                MODE_STR, MODE_ESC: begin
                    m[0] = f_err(jsu_pkg::ERR_UNTERMINATED);
                    m_n  = 3'd1;
                end
                MODE_HEX, MODE_PAIR_HEX: begin
                    m[0] = f_err(jsu_pkg::ERR_BAD_HEX);
                    m_n  = 3'd1;
                end
                MODE_PAIR_BS, MODE_PAIR_U: begin
                    h_emit = 1'b1;
                    m[0]   = f_err(jsu_pkg::ERR_UNTERMINATED);
                    m_n    = 3'd1;
                end
                default: ;
            endcase
            n_mode = MODE_IDLE;
        end else begin
            case (r_mode)
                MODE_STR, MODE_PAIR_BS: begin
                    if (r_mode == MODE_PAIR_BS && c == CH_BSLASH) begin
                        n_mode = MODE_PAIR_U;
                    end else begin
                        h_emit = (r_mode == MODE_PAIR_BS);
                        m[0]   = st.res;
                        m_n    = {2'b00, st.has};
                        n_mode = st.mode;
                    end
                end
                MODE_ESC, MODE_PAIR_U: begin
                    if (r_mode == MODE_PAIR_U && c == CH_U) begin
                        n_acc  = '0;
                        n_cnt  = '0;
                        n_mode = MODE_PAIR_HEX;
                    end else begin
                        h_emit = (r_mode == MODE_PAIR_U);
                        m[0]   = es.res;
                        m_n    = {2'b00, es.has};
                        n_mode = es.mode;
                        if (es.hex_clr) begin
                            n_acc = '0;
                            n_cnt = '0;
                        end
                    end
                end
                MODE_HEX, MODE_PAIR_HEX: begin
                    if (!hx[4]) begin
                        m[0]   = f_err(jsu_pkg::ERR_BAD_HEX);
                        m_n    = 3'd1;
                        n_mode = MODE_IDLE;
                    end else begin
                        n_acc = acc_sh;
                        n_cnt = r_cnt + 2'd1;
                        if (r_cnt == 2'd3) begin
                            if (r_mode == MODE_PAIR_HEX && acc_sh[15:10] == 6'b110111) begin
                                // surrogate pair joins into one 4-byte sequence
                                m[0]   = f_byte({5'b11110, cp[20:18]});
                                m[1]   = f_byte({2'b10, cp[17:12]});
                                m[2]   = f_byte({2'b10, cp[11:6]});
                                m[3]   = f_byte({2'b10, cp[5:0]});
                                m_n    = 3'd4;
                                n_mode = MODE_STR;
                            end else begin
                                h_emit = (r_mode == MODE_PAIR_HEX);
                                if (acc_sh[15:10] == 6'b110110) begin
                                    n_held = acc_sh[9:0];
                                    n_mode = MODE_PAIR_BS;
                                end else begin
                                    for (int i = 0; i < 3; i++) begin
                                        m[i] = f_byte(u_val.b[i]);
                                    end
                                    m_n    = {1'b0, u_val.n};
                                    n_mode = MODE_STR;
                                end
                            end
                        end
                    end
                end
                default: begin
                    if (c == CH_QUOTE) begin
                        n_mode = MODE_STR;
                    end else begin
                        m[0]   = f_err(jsu_pkg::ERR_NO_QUOTE);
                        m_n    = 3'd1;
                        n_mode = MODE_IDLE;
                    end
                end
            endcase
        end
    end

    // held surrogate bytes go first, the item's own results after them
    always_comb begin
        o_cmd = '0;
        if (h_emit) begin
            for (int i = 0; i < 3; i++) begin
                o_cmd.slot[i]     = f_byte(u_held.b[i]);
                o_cmd.slot[i + 3] = m[i];
            end
            o_cmd.count = 3'd3 + m_n;
        end else begin
            for (int i = 0; i < 4; i++) begin
                o_cmd.slot[i] = m[i];
            end
            o_cmd.count = m_n;
        end
    end

    assign o_cmd_valid = accept && (o_cmd.count != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_held <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_held <= n_held;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/jsu_queue.sv -----
// Command queue between parser front end and result back end.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire jsu_pkg::t_cmd i_cmd,
    input  wire logic          i_rd,
    output logic               o_full,
    output logic               o_valid,
    output jsu_pkg::t_cmd      o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    jsu_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + AW'(1);
            end
            if (rd_en) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/jsu_back.sv -----
// Result back end: walks the slots of the head command, one result per
// transfer, and marks the final one. Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire jsu_pkg::t_cmd i_head,
    input  wire logic          i_pop,
    output logic               o_rd,
    output logic               o_empty,
    output jsu_pkg::t_out      o_result
);

    logic [2:0]     r_idx;
    jsu_pkg::t_slot cur;
    logic           is_last;
    logic           xfer;

    assign cur     = i_head.slot[r_idx];
    assign is_last = (r_idx == i_head.count - 3'd1);
    assign xfer    = i_pop && i_valid;
    assign o_rd    = xfer && is_last;
    assign o_empty = !i_valid;

    assign o_result.kind       = cur.kind;
    assign o_result.out_byte   = cur.out_byte;
    assign o_result.error_code = cur.error_code;
    assign o_result.last       = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (xfer) begin
            r_idx <= is_last ? 3'd0 : r_idx + 3'd1;
        end
    end

endmodule

`default_nettype wire
